/* rtl/rtp_frame_reorder_buffer_defines.svh */
// assertion macros for the rtp frame reorder buffer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RTP_FRAME_REORDER_BUFFER_DEFINES_SVH
`define RTP_FRAME_REORDER_BUFFER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RFRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rfrb_pkg.sv */
// shared types, codes and constants of the rtp frame reorder buffer
// no dependencies
`default_nettype none

package rfrb_pkg;

    localparam int RFRB_SLOTS  = 512;
    localparam int RFRB_FRAMES = 4;

    localparam logic [24:0] BYTES_MAX = 25'h1ff_ffff;
    localparam logic [9:0]  PKTS_MAX  = 10'h3ff;

    // register reset values
    localparam logic [1:0]  DEPTH_RST    = 2'd2;
    localparam logic [15:0] JUMP_RST     = 16'd32768;
    localparam logic [4:0]  LATE_RST     = 5'd10;
    localparam logic [24:0] OUTBUF_RST   = 25'd1048576;

    typedef enum logic [1:0] {
        REG_FRAME_DEPTH  = 2'd0,
        REG_MAX_SEQ_JUMP = 2'd1,
        REG_MAX_LATE     = 2'd2,
        REG_OUT_BUFFER   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        INS_STORED = 3'd0,
        INS_NEW    = 3'd1,
        INS_DUP    = 3'd2,
        INS_FULL   = 3'd3,
        INS_RANGE  = 3'd4
    } ins_status_t;

    typedef enum logic [1:0] {
        FST_OK    = 2'd0,
        FST_GAP   = 2'd1,
        FST_EMPTY = 2'd2,
        FST_OVER  = 2'd3
    } frm_status_t;

    typedef struct packed {
        logic [1:0]  frame_depth;
        logic [15:0] max_seq_jump;
        logic [4:0]  max_late;
        logic [24:0] out_buffer_bytes;
    } cfg_t;

    // one slot entry of the packet memory
    typedef struct packed {
        logic        occ;
        logic        mark;
        logic [15:0] bytes;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/rfrb_slot_mem.sv */
// slot memory: one write port, one read port, registered read data
// depends on rfrb_pkg
`default_nettype none

module rfrb_slot_mem #(
    parameter int AW = 11
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire rfrb_pkg::slot_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output rfrb_pkg::slot_t      rdata
);
    import rfrb_pkg::*;

    slot_t mem [2**AW];
    slot_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/rfrb_cfg_regs.sv */
// apb configuration registers of the reorder buffer
// depends on rfrb_pkg
`default_nettype none

module rfrb_cfg_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output rfrb_pkg::cfg_t    cfg
);
    import rfrb_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t ridx;

    assign ridx   = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_depth      <= DEPTH_RST;
            cfg_reg.max_seq_jump     <= JUMP_RST;
            cfg_reg.max_late         <= LATE_RST;
            cfg_reg.out_buffer_bytes <= OUTBUF_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_FRAME_DEPTH:  cfg_reg.frame_depth      <= pwdata[1:0];
                REG_MAX_SEQ_JUMP: cfg_reg.max_seq_jump     <= pwdata[15:0];
                REG_MAX_LATE:     cfg_reg.max_late         <= pwdata[4:0];
                REG_OUT_BUFFER:   cfg_reg.out_buffer_bytes <= pwdata[24:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (ridx)
            REG_FRAME_DEPTH:  prdata = {30'd0, cfg_reg.frame_depth};
            REG_MAX_SEQ_JUMP: prdata = {16'd0, cfg_reg.max_seq_jump};
            REG_MAX_LATE:     prdata = {27'd0, cfg_reg.max_late};
            REG_OUT_BUFFER:   prdata = {7'd0, cfg_reg.out_buffer_bytes};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/rfrb_ctrl.sv */
// sequencer of the reorder buffer: frame table, insert, shift and release scan
// depends on rfrb_pkg; drives the slot memory ports
`default_nettype none

module rfrb_ctrl #(
    parameter int SLOTS  = rfrb_pkg::RFRB_SLOTS,
    parameter int FRAMES = rfrb_pkg::RFRB_FRAMES,
    parameter int SW     = $clog2(SLOTS),
    parameter int FW     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int AW     = FW + SW
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rfrb_pkg::cfg_t  cfg,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [31:0]     timestamp,
    input  wire logic [15:0]     seq_number,
    input  wire logic            marker,
    input  wire logic [6:0]      payload_type,
    input  wire logic [15:0]     payload_bytes,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [2:0]           insert_status,
    output logic                 frame_released,
    output logic [1:0]           frame_status,
    output logic [31:0]          frame_timestamp,
    output logic [6:0]           frame_payload_type,
    output logic [9:0]           frame_packets,
    output logic [24:0]          frame_bytes,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output rfrb_pkg::slot_t      mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  wire rfrb_pkg::slot_t mem_rdata
);
    import rfrb_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int OW = $clog2(FRAMES + 1);
    localparam logic signed [17:0] SLOTS_S = 18'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_LOOK   = 10'b00_0000_0100,
        S_CHECK  = 10'b00_0000_1000,
        S_SHIFT  = 10'b00_0001_0000,
        S_RELCHK = 10'b00_0010_0000,
        S_SCAN   = 10'b00_0100_0000,
        S_OUT    = 10'b00_1000_0000,
        S_SPARE1 = 10'b01_0000_0000,
        S_SPARE2 = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    // latched input word
    logic [31:0] ts_reg;
    logic [15:0] seq_reg;
    logic        mk_reg;
    logic [6:0]  pt_reg;
    logic [15:0] nb_reg;
    slot_t       info;

    // frame table
    logic          fvalid_reg [FRAMES];
    logic [31:0]   fts_reg    [FRAMES];
    logic [6:0]    fpt_reg    [FRAMES];
    logic [15:0]   fbase_reg  [FRAMES];
    logic [CW-1:0] fcnt_reg   [FRAMES];
    logic [FW-1:0] head_reg;
    logic [OW-1:0] open_reg;

    // working registers
    logic [FW-1:0]       f_reg;
    logic [15:0]         idx_reg;
    logic signed [17:0]  diff_reg;
    logic [4:0]          d_reg;
    logic [SW-1:0]       j_reg;
    logic                issue_done_reg;
    logic                pend_reg;
    logic [SW-1:0]       pend_j_reg;
    logic                pend_mem_reg;
    logic [CW-1:0]       cnt_reg;
    logic [24:0]         total_reg;
    logic [9:0]          pkts_reg;
    logic                gap_reg;
    logic                search_reg;
    logic [AW-1:0]       clr_reg;

    // result under construction
    logic [2:0]  res_ins_reg;
    logic        res_rel_reg;
    logic [1:0]  res_fst_reg;
    logic [31:0] res_ts_reg;
    logic [6:0]  res_pt_reg;
    logic [9:0]  res_pk_reg;
    logic [24:0] res_by_reg;

    // output register
    logic        out_valid_reg;
    logic [2:0]  o_ins_reg;
    logic        o_rel_reg;
    logic [1:0]  o_fst_reg;
    logic [31:0] o_ts_reg;
    logic [6:0]  o_pt_reg;
    logic [9:0]  o_pk_reg;
    logic [24:0] o_by_reg;

    // lookup and offset logic
    logic               found;
    logic [FW-1:0]      fpos;
    logic [FW-1:0]      npos;
    logic [FW-1:0]      head_inc;
    logic [FW:0]        psum;
    logic [FW:0]        nsum;
    logic [15:0]        base;
    logic signed [17:0] dif0;
    logic signed [17:0] mag;
    logic signed [17:0] dif;
    logic [15:0]        idx;

    // check and scan logic
    logic          chk_dup;
    logic          chk_full;
    logic          chk_range;
    logic [25:0]   tot_sum;
    logic [24:0]   tot_next;
    logic [9:0]    pk_next;
    logic          gap_next;
    logic          search_next;
    logic [1:0]    depth_eff;
    frm_status_t   fst_next;
    logic          out_load;

    assign info = '{occ: 1'b1, mark: mk_reg, bytes: nb_reg};

    // frame lookup by timestamp over the open frames, oldest first
    always_comb
    begin
        found = 1'b0;
        fpos  = '0;
        psum  = '0;
        for (int k = 0; k < FRAMES; k++)
        begin
            psum = (FW+1)'(head_reg) + (FW+1)'(k);
            if (psum >= (FW+1)'(FRAMES))
            begin
                psum = psum - (FW+1)'(FRAMES);
            end
            if (!found && (OW'(k) < open_reg) && fvalid_reg[FW'(psum)]
                && (fts_reg[FW'(psum)] == ts_reg))
            begin
                found = 1'b1;
                fpos  = FW'(psum);
            end
        end
        nsum = (FW+1)'(head_reg) + (FW+1)'(open_reg);
        if (nsum >= (FW+1)'(FRAMES))
        begin
            nsum = nsum - (FW+1)'(FRAMES);
        end
        npos = FW'(nsum);
        if (int'(head_reg) == FRAMES - 1)
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + FW'(1);
        end
    end

    // sequence offset with wrap correction
    always_comb
    begin
        base = fbase_reg[fpos];
        idx  = seq_reg - base;
        dif0 = $signed({2'b00, seq_reg}) - $signed({2'b00, base});
        mag  = (dif0 < 0) ? -dif0 : dif0;
        dif  = dif0;
        if (mag > $signed({2'b00, cfg.max_seq_jump}))
        begin
            dif = (dif0 > 0) ? (dif0 - 18'sd65536) : (dif0 + 18'sd65536);
        end
    end

    // refusal checks, in priority order
    assign chk_dup   = (idx_reg < 16'(SLOTS)) && mem_rdata.occ;
    assign chk_full  = fcnt_reg[f_reg] >= CW'(SLOTS);
    assign chk_range = (diff_reg >= SLOTS_S)
                       || (diff_reg < -$signed({13'd0, cfg.max_late}));

    // release scan accumulation for the slot whose data is back
    always_comb
    begin
        tot_sum     = {1'b0, total_reg} + {10'd0, mem_rdata.bytes};
        tot_next    = total_reg;
        pk_next     = pkts_reg;
        gap_next    = gap_reg;
        search_next = search_reg;
        if (mem_rdata.occ)
        begin
            tot_next = tot_sum[25] ? BYTES_MAX : tot_sum[24:0];
            if (pkts_reg != PKTS_MAX)
            begin
                pk_next = pkts_reg + 10'd1;
            end
        end
        if (pend_j_reg == '0)
        begin
            search_next = !mem_rdata.mark;
        end
        else if (search_reg)
        begin
            if (!mem_rdata.occ)
            begin
                gap_next    = 1'b1;
                search_next = 1'b0;
            end
            else if (mem_rdata.mark)
            begin
                search_next = 1'b0;
            end
        end
        if (gap_next)
        begin
            fst_next = FST_GAP;
        end
        else if (tot_next == '0)
        begin
            fst_next = FST_EMPTY;
        end
        else if (tot_next > cfg.out_buffer_bytes)
        begin
            fst_next = FST_OVER;
        end
        else
        begin
            fst_next = FST_OK;
        end
        if (int'(cfg.frame_depth) > FRAMES - 1)
        begin
            depth_eff = 2'(FRAMES - 1);
        end
        else
        begin
            depth_eff = cfg.frame_depth;
        end
    end

    // slot memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            S_LOOK:
            begin
                mem_raddr = {fpos, idx[SW-1:0]};
                if (!found)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {npos, SW'(0)};
                    mem_wdata = info;
                end
            end
            S_CHECK:
            begin
                if (!chk_dup && !chk_full && !chk_range && (diff_reg >= 0))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {f_reg, diff_reg[SW-1:0]};
                    mem_wdata = info;
                end
            end
            S_SHIFT:
            begin
                mem_raddr = {f_reg, j_reg - SW'(d_reg)};
                mem_we    = pend_reg;
                mem_waddr = {f_reg, pend_j_reg};
                if (pend_j_reg == '0)
                begin
                    mem_wdata = info;
                end
                else if (pend_mem_reg)
                begin
                    mem_wdata = mem_rdata;
                end
            end
            S_SCAN:
            begin
                mem_raddr = {head_reg, j_reg};
                mem_we    = pend_reg;
                mem_waddr = {head_reg, pend_j_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            head_reg       <= '0;
            open_reg       <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                fvalid_reg[i] <= 1'b0;
                fcnt_reg[i]   <= '0;
            end
        end
        else
        begin
            case (state_reg)
                // zero the slot memory once after reset
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ts_reg      <= timestamp;
                        seq_reg     <= seq_number;
                        mk_reg      <= marker;
                        pt_reg      <= payload_type;
                        nb_reg      <= payload_bytes;
                        res_rel_reg <= 1'b0;
                        res_fst_reg <= FST_OK;
                        res_ts_reg  <= '0;
                        res_pt_reg  <= '0;
                        res_pk_reg  <= '0;
                        res_by_reg  <= '0;
                        state_reg   <= S_LOOK;
                    end
                end
                // open a new frame or read the target slot
                S_LOOK:
                begin
                    if (!found)
                    begin
                        fvalid_reg[npos] <= 1'b1;
                        fts_reg[npos]    <= ts_reg;
                        fpt_reg[npos]    <= pt_reg;
                        fbase_reg[npos]  <= seq_reg;
                        fcnt_reg[npos]   <= CW'(1);
                        open_reg         <= open_reg + OW'(1);
                        res_ins_reg      <= INS_NEW;
                        state_reg        <= S_RELCHK;
                    end
                    else
                    begin
                        f_reg     <= fpos;
                        idx_reg   <= idx;
                        diff_reg  <= dif;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (chk_dup)
                    begin
                        res_ins_reg <= INS_DUP;
                        state_reg   <= S_RELCHK;
                    end
                    else if (chk_full)
                    begin
                        res_ins_reg <= INS_FULL;
                        state_reg   <= S_OUT;
                    end
                    else if (chk_range)
                    begin
                        res_ins_reg <= INS_RANGE;
                        state_reg   <= S_OUT;
                    end
                    else if (diff_reg >= 0)
                    begin
                        fcnt_reg[f_reg] <= fcnt_reg[f_reg] + CW'(1);
                        res_ins_reg     <= INS_STORED;
                        state_reg       <= S_RELCHK;
                    end
                    else
                    begin
                        d_reg          <= 5'(-diff_reg);
                        j_reg          <= LAST_SLOT;
                        issue_done_reg <= 1'b0;
                        pend_reg       <= 1'b0;
                        cnt_reg        <= CW'(1);
                        state_reg      <= S_SHIFT;
                    end
                end
                // move the frame up by d slots, top slot first
                S_SHIFT:
                begin
                    if (pend_reg && pend_mem_reg && mem_rdata.occ)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (!issue_done_reg)
                    begin
                        pend_reg     <= 1'b1;
                        pend_j_reg   <= j_reg;
                        pend_mem_reg <= int'(j_reg) >= int'(d_reg);
                        if (j_reg == '0)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            j_reg <= j_reg - SW'(1);
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && (pend_j_reg == '0))
                    begin
                        fbase_reg[f_reg] <= seq_reg;
                        fcnt_reg[f_reg]  <= cnt_reg;
                        res_ins_reg      <= INS_STORED;
                        state_reg        <= S_RELCHK;
                    end
                end
                S_RELCHK:
                begin
                    if (open_reg > OW'(depth_eff))
                    begin
                        j_reg          <= '0;
                        issue_done_reg <= 1'b0;
                        pend_reg       <= 1'b0;
                        total_reg      <= '0;
                        pkts_reg       <= '0;
                        gap_reg        <= 1'b0;
                        search_reg     <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                // read, total and clear every slot of the oldest frame
                S_SCAN:
                begin
                    if (pend_reg)
                    begin
                        total_reg  <= tot_next;
                        pkts_reg   <= pk_next;
                        gap_reg    <= gap_next;
                        search_reg <= search_next;
                    end
                    if (!issue_done_reg)
                    begin
                        pend_reg   <= 1'b1;
                        pend_j_reg <= j_reg;
                        if (j_reg == LAST_SLOT)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            j_reg <= j_reg + SW'(1);
                        end
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && (pend_j_reg == LAST_SLOT))
                    begin
                        res_rel_reg          <= 1'b1;
                        res_fst_reg          <= fst_next;
                        res_ts_reg           <= fts_reg[head_reg];
                        res_pt_reg           <= fpt_reg[head_reg];
                        res_pk_reg           <= pk_next;
                        res_by_reg           <= tot_next;
                        fvalid_reg[head_reg] <= 1'b0;
                        fcnt_reg[head_reg]   <= '0;
                        head_reg             <= head_inc;
                        open_reg             <= open_reg - OW'(1);
                        state_reg            <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_ins_reg <= res_ins_reg;
            o_rel_reg <= res_rel_reg;
            o_fst_reg <= res_fst_reg;
            o_ts_reg  <= res_ts_reg;
            o_pt_reg  <= res_pt_reg;
            o_pk_reg  <= res_pk_reg;
            o_by_reg  <= res_by_reg;
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign insert_status      = o_ins_reg;
    assign frame_released     = o_rel_reg;
    assign frame_status       = o_fst_reg;
    assign frame_timestamp    = o_ts_reg;
    assign frame_payload_type = o_pt_reg;
    assign frame_packets      = o_pk_reg;
    assign frame_bytes        = o_by_reg;

endmodule

`default_nettype wire

/* rtl/rtp_frame_reorder_buffer.sv */
// top level of the rtp frame reorder buffer
// depends on rfrb_pkg, rfrb_cfg_regs, rfrb_ctrl and rfrb_slot_mem
//
//   port group | direction | handshake           | content
//   -----------+-----------+---------------------+-------------------------------
//   input      | in        | in_valid / in_stall | one packet descriptor word
//   output     | out       | out_valid/out_stall | insert status and released frame
//   config     | in        | apb psel/penable    | four registers at 4*index
//
// new frame: look, release check, output; refused: look, check, output;
// stored or duplicate packet: look, check, release check, output.
// a late packet adds a slot shift through the memory port; a release adds a scan
// and clear of the oldest frame. after reset the slot memory is zeroed; in_stall
// is high meanwhile.
// in_stall stays high while a word is at work; the output register holds on out_stall.
`default_nettype none

module rtp_frame_reorder_buffer #(
    parameter int SLOTS  = rfrb_pkg::RFRB_SLOTS,
    parameter int FRAMES = rfrb_pkg::RFRB_FRAMES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] timestamp,
    input  wire logic [15:0] seq_number,
    input  wire logic        marker,
    input  wire logic [6:0]  payload_type,
    input  wire logic [15:0] payload_bytes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       insert_status,
    output logic             frame_released,
    output logic [1:0]       frame_status,
    output logic [31:0]      frame_timestamp,
    output logic [6:0]       frame_payload_type,
    output logic [9:0]       frame_packets,
    output logic [24:0]      frame_bytes
);
    import rfrb_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AW = FW + SW;

    cfg_t          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic [AW-1:0] mem_raddr;
    slot_t         mem_rdata;

    // configuration registers
    rfrb_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer and frame table
    rfrb_ctrl #(
        .SLOTS  (SLOTS),
        .FRAMES (FRAMES),
        .SW     (SW),
        .FW     (FW),
        .AW     (AW)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .timestamp          (timestamp),
        .seq_number         (seq_number),
        .marker             (marker),
        .payload_type       (payload_type),
        .payload_bytes      (payload_bytes),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .insert_status      (insert_status),
        .frame_released     (frame_released),
        .frame_status       (frame_status),
        .frame_timestamp    (frame_timestamp),
        .frame_payload_type (frame_payload_type),
        .frame_packets      (frame_packets),
        .frame_bytes        (frame_bytes),
        .mem_we             (mem_we),
        .mem_waddr          (mem_waddr),
        .mem_wdata          (mem_wdata),
        .mem_raddr          (mem_raddr),
        .mem_rdata          (mem_rdata)
    );

    // packet slot memory
    rfrb_slot_mem #(
        .AW (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* rtl/rfrb_checker.sv */
// port-level checks of the rtp frame reorder buffer, bound to the top level
// depends on rfrb_pkg and rtp_frame_reorder_buffer_defines.svh
`default_nettype none
`include "rtp_frame_reorder_buffer_defines.svh"

module rfrb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  insert_status,
    input wire logic        frame_released,
    input wire logic [1:0]  frame_status,
    input wire logic [31:0] frame_timestamp,
    input wire logic [9:0]  frame_packets,
    input wire logic [24:0] frame_bytes
);
    import rfrb_pkg::*;

    logic refused;
    logic frame_zero;

    assign refused    = (insert_status == INS_FULL) || (insert_status == INS_RANGE);
    assign frame_zero = (frame_status == FST_OK) && (frame_packets == 10'd0)
                        && (frame_bytes == 25'd0) && (frame_timestamp == 32'd0);

    // a stalled word stays offered
    `RFRB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped")

    // only the five status codes appear
    `RFRB_ASSERT_NOW(a_ins_code, out_valid, insert_status <= INS_RANGE, "bad insert status")

    // a refused packet never releases a frame
    `RFRB_ASSERT_NOW(a_refuse_norel, out_valid && refused, !frame_released, "refused release")

    // frame fields are zero when nothing was released
    `RFRB_ASSERT_NOW(a_norel_zero, out_valid && !frame_released, frame_zero, "frame fields set")

    // a released frame always holds its first packet
    `RFRB_ASSERT_NOW(a_rel_nonempty, out_valid && frame_released, frame_packets != 10'd0, "empty")

endmodule

bind rtp_frame_reorder_buffer rfrb_checker u_rfrb_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .insert_status      (insert_status),
    .frame_released     (frame_released),
    .frame_status       (frame_status),
    .frame_timestamp    (frame_timestamp),
    .frame_packets      (frame_packets),
    .frame_bytes        (frame_bytes)
);

`default_nettype wire

/* tb/rtp_frame_reorder_buffer_test.sv */
// self-checking testbench of rtp_frame_reorder_buffer: packet words in, one result word each
// depends on rfrb_pkg and the rtl of the block; a built-in frame predictor supplies expectations
`default_nettype none

module rtp_frame_reorder_buffer_test;
    import rfrb_pkg::*;

    localparam int NSLOT = RFRB_SLOTS;
    localparam int NFRM = RFRB_FRAMES;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int SETTLE_CYCLES = 2 * NSLOT + 32;

    typedef struct {
        logic [31:0] ts;
        logic [15:0] seq;
        logic        mk;
        logic [6:0]  pt;
        logic [15:0] nb;
    } pkt_t;

    typedef struct {
        ins_status_t ins;
        logic        rel;
        frm_status_t fst;
        logic [31:0] fts;
        logic [6:0]  fpt;
        logic [9:0]  fpkts;
        logic [24:0] fbytes;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [31:0] timestamp;
    logic [15:0] seq_number;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] payload_bytes;
    logic        out_valid, out_stall;
    logic [2:0]  insert_status;
    logic        frame_released;
    logic [1:0]  frame_status;
    logic [31:0] frame_timestamp;
    logic [6:0]  frame_payload_type;
    logic [9:0]  frame_packets;
    logic [24:0] frame_bytes;

    rtp_frame_reorder_buffer dut (.*);

    // predictor state: registers and frame store
    logic [1:0]  cfg_depth;
    logic [15:0] cfg_jump;
    logic [4:0]  cfg_late;
    logic [24:0] cfg_obuf;
    bit          fr_open [NFRM];
    logic [31:0] fr_ts [NFRM];
    logic [6:0]  fr_pt [NFRM];
    logic [15:0] fr_base [NFRM];
    int          fr_cnt [NFRM];
    int          ring_head;
    int          n_open;
    bit          slot_used [NFRM][NSLOT];
    logic [16:0] slot_val [NFRM][NSLOT];

    verdict_t pending_results[$];
    int       fail_count;
    int       cycle_count;
    int       sent_count;
    int       gap_pct;
    int       stall_pct;

    // clock
    always #4 clk = ~clk;

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void clear_frame(int f);
        for (int j = 0; j < NSLOT; j++)
        begin
            slot_used[f][j] = 0;
            slot_val[f][j] = '0;
        end
        fr_cnt[f] = 0;
        fr_open[f] = 0;
    endfunction

    function automatic void predictor_reset();
        cfg_depth = DEPTH_RST;
        cfg_jump = JUMP_RST;
        cfg_late = LATE_RST;
        cfg_obuf = OUTBUF_RST;
        for (int f = 0; f < NFRM; f++)
            clear_frame(f);
        ring_head = 0;
        n_open = 0;
    endfunction

    // slot insert inside an open frame, returns the insert code
    function automatic ins_status_t place_packet(int f, logic [15:0] seq, logic [16:0] v);
        logic [15:0] idx;
        int diff, mag, d, cnt;
        idx = seq - fr_base[f];
        diff = int'(seq) - int'(fr_base[f]);
        mag = diff < 0 ? -diff : diff;
        if (mag > int'(cfg_jump))
            diff = diff > 0 ? diff - 65536 : diff + 65536;
        if (idx < NSLOT && slot_used[f][idx])
            return INS_DUP;
        if (fr_cnt[f] >= NSLOT)
            return INS_FULL;
        if (diff >= NSLOT || diff < -int'(cfg_late))
            return INS_RANGE;
        if (diff < 0)
        begin
            d = -diff;
            for (int j = NSLOT - 1; j >= 0; j--)
            begin
                if (j >= d)
                begin
                    slot_used[f][j] = slot_used[f][j - d];
                    slot_val[f][j] = slot_val[f][j - d];
                end
                else
                begin
                    slot_used[f][j] = 0;
                    slot_val[f][j] = '0;
                end
            end
            slot_used[f][0] = 1;
            slot_val[f][0] = v;
            fr_base[f] = seq;
            cnt = 0;
            for (int j = 0; j < NSLOT; j++)
                if (slot_used[f][j])
                    cnt++;
            fr_cnt[f] = cnt;
            return INS_STORED;
        end
        slot_used[f][diff] = 1;
        slot_val[f][diff] = v;
        fr_cnt[f]++;
        return INS_STORED;
    endfunction

    // release of the oldest frame with completeness check
    function automatic void release_oldest(ref verdict_t r);
        int f, total, pkts;
        bit gap;
        f = ring_head % NFRM;
        gap = 0;
        total = 0;
        pkts = 0;
        if (!slot_val[f][0][16])
        begin
            for (int j = 1; j < NSLOT; j++)
            begin
                if (!slot_used[f][j])
                begin
                    gap = 1;
                    break;
                end
                if (slot_val[f][j][16])
                    break;
            end
        end
        for (int j = 0; j < NSLOT; j++)
        begin
            if (slot_used[f][j])
            begin
                total += slot_val[f][j][15:0];
                if (total > BYTES_MAX)
                    total = BYTES_MAX;
                if (pkts < PKTS_MAX)
                    pkts++;
            end
        end
        r.rel = 1;
        if (gap)
            r.fst = FST_GAP;
        else if (total == 0)
            r.fst = FST_EMPTY;
        else if (total > cfg_obuf)
            r.fst = FST_OVER;
        else
            r.fst = FST_OK;
        r.fts = fr_ts[f];
        r.fpt = fr_pt[f];
        r.fpkts = 10'(pkts);
        r.fbytes = 25'(total);
        clear_frame(f);
        ring_head = (ring_head + 1) % NFRM;
        n_open--;
    endfunction

    function automatic verdict_t predict_frame_result(pkt_t p);
        verdict_t r;
        logic [16:0] v;
        int f, depth;
        bit found;
        r = '{INS_STORED, 0, FST_OK, '0, '0, '0, '0};
        v = {p.mk, p.nb};
        found = 0;
        f = 0;
        for (int k = 0; k < n_open && k < NFRM; k++)
        begin
            if (fr_open[(ring_head + k) % NFRM] && fr_ts[(ring_head + k) % NFRM] == p.ts)
            begin
                f = (ring_head + k) % NFRM;
                found = 1;
                break;
            end
        end
        if (!found)
        begin
            f = (ring_head + n_open) % NFRM;
            clear_frame(f);
            fr_open[f] = 1;
            fr_ts[f] = p.ts;
            fr_pt[f] = p.pt;
            fr_base[f] = p.seq;
            slot_used[f][0] = 1;
            slot_val[f][0] = v;
            fr_cnt[f] = 1;
            n_open++;
            r.ins = INS_NEW;
        end
        else
        begin
            r.ins = place_packet(f, p.seq, v);
            if (r.ins == INS_FULL || r.ins == INS_RANGE)
                return r;
        end
        depth = cfg_depth > NFRM - 1 ? NFRM - 1 : cfg_depth;
        if (n_open > depth)
            release_oldest(r);
        return r;
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                verdict_t e;
                e = pending_results.pop_front();
                if (insert_status !== e.ins)
                begin
                    $error("insert_status exp %0d got %0d", e.ins, insert_status);
                    fail_count++;
                end
                if (frame_released !== e.rel)
                begin
                    $error("frame_released exp %0d got %0d", e.rel, frame_released);
                    fail_count++;
                end
                if (frame_status !== e.fst)
                begin
                    $error("frame_status exp %0d got %0d", e.fst, frame_status);
                    fail_count++;
                end
                if (frame_timestamp !== e.fts)
                begin
                    $error("frame_timestamp exp %0h got %0h", e.fts, frame_timestamp);
                    fail_count++;
                end
                if (frame_payload_type !== e.fpt)
                begin
                    $error("frame_payload_type exp %0d got %0d", e.fpt, frame_payload_type);
                    fail_count++;
                end
                if (frame_packets !== e.fpkts)
                begin
                    $error("frame_packets exp %0d got %0d", e.fpkts, frame_packets);
                    fail_count++;
                end
                if (frame_bytes !== e.fbytes)
                begin
                    $error("frame_bytes exp %0d got %0d", e.fbytes, frame_bytes);
                    fail_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one packet word, predict at acceptance, then maybe idle
    task automatic send_packet(pkt_t p);
        in_valid <= 1'b1;
        timestamp <= p.ts;
        seq_number <= p.seq;
        marker <= p.mk;
        payload_type <= p.pt;
        payload_bytes <= p.nb;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_frame_result(p));
        sent_count++;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [31:0] ts, logic [15:0] seq, logic mk,
                               logic [6:0] pt, logic [15:0] nb);
        pkt_t p;
        p = '{ts, seq, mk, pt, nb};
        send_packet(p);
    endtask

    // wait until every result is in and the block has finished its work
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t r, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_FRAME_DEPTH:  cfg_depth = value[1:0];
            REG_MAX_SEQ_JUMP: cfg_jump = value[15:0];
            REG_MAX_LATE:     cfg_late = value[4:0];
            REG_OUT_BUFFER:   cfg_obuf = value[24:0];
            default:          cfg_depth = cfg_depth;
        endcase
    endtask

    // wrap, duplicate, late, range, empty and gap frames at reset settings
    task automatic test_directed_cases();
        send_fields(32'h0000_0000, 16'hffff, 1'b0, 7'd127, 16'hffff);
        send_fields(32'h0000_0000, 16'h0001, 1'b1, 7'd0, 16'd100);
        send_fields(32'h0000_0000, 16'h0001, 1'b0, 7'd5, 16'd7);
        send_fields(32'h0000_0000, 16'hfffd, 1'b0, 7'd3, 16'd1);
        send_fields(32'h0000_0000, 16'hffe0, 1'b0, 7'd3, 16'd1);
        send_fields(32'h0000_0000, 16'd600, 1'b0, 7'd3, 16'd1);
        send_fields(32'hffff_ffff, 16'h0000, 1'b0, 7'd1, 16'd0);
        send_fields(32'hffff_ffff, 16'h0001, 1'b1, 7'd1, 16'd0);
        send_fields(32'h1234_5678, 16'h8000, 1'b0, 7'd64, 16'd10);
        send_fields(32'h1234_5678, 16'h8002, 1'b1, 7'd64, 16'd10);
        send_fields(32'h5555_aaaa, 16'h7fff, 1'b0, 7'd9, 16'd1);
        send_fields(32'h5555_aaaa, 16'h81ff, 1'b0, 7'd9, 16'd1);
        send_fields(32'haaaa_5555, 16'h0010, 1'b1, 7'd42, 16'd1000);
        send_fields(32'h0f0f_0f0f, 16'h0020, 1'b0, 7'd2, 16'd1);
        send_fields(32'h0f0f_0f0f, 16'h0021, 1'b0, 7'd2, 16'd1);
        send_fields(32'hf0f0_f0f0, 16'h0000, 1'b1, 7'd2, 16'd1);
        drain_results();
    endtask

    // a frame filled to every slot, then duplicate and full refusals
    task automatic test_full_frame();
        for (int i = 0; i < NSLOT; i++)
            send_fields(32'hcafe_0001, 16'hfff0 + i[15:0], i == NSLOT - 1, 7'd33, 16'hffff);
        send_fields(32'hcafe_0001, 16'hfff0, 1'b0, 7'd33, 16'd5);
        send_fields(32'hcafe_0001, 16'hfff0 + NSLOT[15:0], 1'b0, 7'd33, 16'd5);
        send_fields(32'hcafe_0002, 16'h0001, 1'b1, 7'd1, 16'd1);
        send_fields(32'hcafe_0003, 16'h0001, 1'b1, 7'd1, 16'd1);
        drain_results();
    endtask

    // one burst of interleaved frames, mostly well formed
    task automatic send_frame_burst();
        pkt_t burst[$];
        pkt_t p, t;
        int nf, n, k, skip;
        logic [31:0] ts;
        logic [15:0] base;
        logic [6:0] pt;
        nf = int'($urandom_range(1, 3));
        for (int f = 0; f < nf; f++)
        begin
            ts = $urandom;
            base = ($urandom_range(3) == 0) ? 16'hffff - 16'($urandom_range(6))
                                            : 16'($urandom);
            pt = 7'($urandom);
            n = ($urandom_range(15) == 0) ? int'($urandom_range(20, 40))
                                          : int'($urandom_range(1, 8));
            skip = ($urandom_range(99) < 15) ? int'($urandom_range(1, n)) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == skip)
                    continue;
                p.ts = ts;
                p.seq = base + i[15:0];
                p.mk = (i == n - 1) && ($urandom_range(9) != 0);
                p.pt = ($urandom_range(19) == 0) ? 7'($urandom) : pt;
                case ($urandom_range(9))
                    0:       p.nb = 16'd0;
                    1:       p.nb = 16'hffff - 16'($urandom_range(255));
                    default: p.nb = 16'($urandom_range(1500));
                endcase
                burst.push_back(p);
                if ($urandom_range(99) < 8)
                    burst.push_back(p);
            end
            if ($urandom_range(99) < 12)
            begin
                p.seq = base - 16'($urandom_range(1, cfg_late + 2));
                p.mk = 1'b0;
                burst.push_back(p);
            end
            if ($urandom_range(99) < 6)
            begin
                p.seq = base + 16'($urandom_range(NSLOT - 2, NSLOT + 40));
                burst.push_back(p);
            end
            if ($urandom_range(99) < 6)
            begin
                p.seq = 16'($urandom);
                burst.push_back(p);
            end
        end
        // reorder a little, more for some bursts
        k = ($urandom_range(3) == 0) ? burst.size() : burst.size() / 4;
        for (int i = 0; i < k && burst.size() > 1; i++)
        begin
            int a, b;
            a = int'($urandom_range(burst.size() - 1));
            b = int'($urandom_range(burst.size() - 1));
            t = burst[a];
            burst[a] = burst[b];
            burst[b] = t;
        end
        // noise word with fully random fields
        if ($urandom_range(99) < 10)
        begin
            p = '{32'($urandom), 16'($urandom), 1'($urandom), 7'($urandom), 16'($urandom)};
            burst.push_back(p);
        end
        foreach (burst[i])
            send_packet(burst[i]);
    endtask

    // whole bursts until about count packet words have gone in
    task automatic run_bursts(int count);
        int start;
        start = sent_count;
        while (sent_count - start < count)
            send_frame_burst();
    endtask

    // register extremes, with a depth drop while frames are open
    task automatic test_register_sweep();
        cfg_write(REG_FRAME_DEPTH, 32'd0);
        cfg_write(REG_MAX_SEQ_JUMP, 32'd1);
        cfg_write(REG_MAX_LATE, 32'd0);
        cfg_write(REG_OUT_BUFFER, 32'd0);
        run_bursts(50);
        drain_results();
        cfg_write(REG_FRAME_DEPTH, 32'd3);
        cfg_write(REG_MAX_SEQ_JUMP, 32'd65535);
        cfg_write(REG_MAX_LATE, 32'd16);
        cfg_write(REG_OUT_BUFFER, 32'h01ff_ffff);
        run_bursts(60);
        send_fields(32'hbeef_0001, 16'd1, 1'b1, 7'd1, 16'd1);
        send_fields(32'hbeef_0002, 16'd1, 1'b1, 7'd1, 16'd1);
        send_fields(32'hbeef_0003, 16'd1, 1'b1, 7'd1, 16'd1);
        drain_results();
        cfg_write(REG_FRAME_DEPTH, 32'd0);
        send_fields(32'hbeef_0004, 16'd9, 1'b0, 7'd4, 16'd4);
        send_fields(32'hbeef_0005, 16'd9, 1'b1, 7'd4, 16'd4);
        drain_results();
        cfg_write(REG_FRAME_DEPTH, 32'd1);
        cfg_write(REG_MAX_SEQ_JUMP, 32'd300);
        cfg_write(REG_MAX_LATE, 32'd5);
        cfg_write(REG_OUT_BUFFER, 32'd3000);
        run_bursts(50);
        drain_results();
        cfg_write(REG_FRAME_DEPTH, 32'(DEPTH_RST));
        cfg_write(REG_MAX_SEQ_JUMP, 32'(JUMP_RST));
        cfg_write(REG_MAX_LATE, 32'(LATE_RST));
        cfg_write(REG_OUT_BUFFER, 32'(OUTBUF_RST));
    endtask

    // random bursts under the three idling mixes
    task automatic test_random_traffic();
        gap_pct = 6;
        stall_pct = 60;
        run_bursts(180);
        drain_results();
        gap_pct = 60;
        stall_pct = 6;
        run_bursts(180);
        gap_pct = 0;
        stall_pct = 0;
        run_bursts(180);
        drain_results();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        in_valid = 0;
        timestamp = '0;
        seq_number = '0;
        marker = 0;
        payload_type = '0;
        payload_bytes = '0;
        out_stall = 0;
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        gap_pct = 6;
        stall_pct = 60;
        predictor_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_frame();
        test_register_sweep();
        test_random_traffic();

        if (fail_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
